// ----- hdl/tfda_pkg.sv -----
// Package for the trip fuel and distance accumulator.
// Holds the shared widths, constants and the request type of the serial
// multiply-divide unit. No dependencies.
package tfda_pkg;

  localparam int unsigned MD_AW = 40;  // product and quotient width
  localparam int unsigned MD_BW = 16;  // multiplier width, one bit per cycle
  localparam int unsigned MD_DW = 11;  // divisor width

  localparam logic [MD_DW-1:0] DIV_DIST   = 11'd36;
  localparam logic [MD_DW-1:0] DIV_PCT    = 11'd100;
  localparam logic [MD_DW-1:0] DIV_FUEL   = 11'd1073;
  localparam logic [10:0]      KELVIN_OFS = 11'd273;
  localparam logic [8:0]       CUT_MARGIN = 9'd4;
  localparam int unsigned      OPEN_LOOP_BIT = 10;
  localparam logic [23:0]      AIR_MAX    = 24'hFFFFFF;
  localparam logic [7:0]       THR_MIN_RESET = 8'd255;
  localparam logic [7:0]       ADJ_RESET  = 8'd100;
  localparam logic [7:0]       DISP_RESET = 8'd20;

  localparam logic CFG_ADJ  = 1'b0;
  localparam logic CFG_DISP = 1'b1;

  typedef struct packed {
    logic [MD_AW-1:0] a;
    logic [MD_BW-1:0] b;
    logic [MD_DW-1:0] d;
  } md_req_t;

endpackage

// ----- hdl/tfda_muldiv.sv -----
// Bit-serial unit computing (a * b) / d: shift-add multiply over the 16
// multiplier bits, then restoring division one quotient bit per cycle.
// Depends on tfda_pkg.
module tfda_muldiv import tfda_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  md_req_t          req,
  output logic             done,
  output logic [MD_AW-1:0] quo
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]       ph_r, ph_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [MD_AW-1:0] a_r, a_nxt;
  logic [MD_BW-1:0] b_r, b_nxt;
  logic [MD_DW-1:0] d_r, d_nxt;
  logic [MD_AW-1:0] acc_r, acc_nxt;
  logic [MD_DW-1:0] rem_r, rem_nxt;
  logic             done_r, done_nxt;
  logic [MD_DW:0]   trial;

  assign trial = {rem_r, acc_r[MD_AW-1]};

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          a_nxt   = req.a;
          b_nxt   = req.b;
          d_nxt   = req.d;
          acc_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = PH_MUL;
        end
      end
      PH_MUL: begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt   = {a_r[MD_AW-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[MD_BW-1:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MD_BW - 1)) begin
          cnt_nxt = '0;
          ph_nxt  = PH_DIV;
        end
      end
      PH_DIV: begin
        // The remainder stays below the divisor, so the trial fits one extra bit.
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = MD_DW'(trial - {1'b0, d_r});
          acc_nxt = {acc_r[MD_AW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[MD_DW-1:0];
          acc_nxt = {acc_r[MD_AW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MD_AW - 1)) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r;

endmodule

// ----- hdl/trip_fuel_distance_accumulator.sv -----
// Trip fuel and distance accumulator, top level.
// Samples arrive on the in_ channel (valid/stall); each accepted sample
// produces TRIP_COUNT result transfers on the out_ channel, trip 0 first,
// with out_last_trip set on the final one. in_stall is high from the
// accepting edge until the last result of that sample has been taken.
// Each multiply-divide runs through one bit-serial multiply-divide unit
// (displacement times 36, the Kelvin offset and the totals are added or
// multiplied outside it). An operation takes 16 multiply bits, then 40
// quotient bits, then hands the quotient back and issues the next one. A
// sample with in_valid_flags[0] set uses one operation for distance and,
// when fuel is computed, four more for fuel. When the receiver stalls, the
// current result holds and the sequencer waits. Synchronous reset clears
// the totals, sets the idle throttle minimum to 255, and loads the register
// defaults (adjust 100, displacement 20 dL). Configuration writes are taken
// on any cycle out of reset in which cfg_we is high. Since no trip is ever
// reset on its own, every trip accumulates the same increments, so one set
// of totals serves all trips.
module trip_fuel_distance_accumulator import tfda_pkg::*; #(
  parameter int unsigned TRIP_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_elapsed_ms,
  input  logic [7:0]  in_speed_kmh,
  input  logic        in_engine_running,
  input  logic [7:0]  in_throttle_position,
  input  logic [15:0] in_fuel_system_status,
  input  logic        in_maf_supported,
  input  logic [15:0] in_maf_reading,
  input  logic [13:0] in_engine_rpm,
  input  logic [7:0]  in_manifold_kpa,
  input  logic signed [8:0] in_intake_temp_c,
  input  logic [6:0]  in_valid_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_trip_number,
  output logic [31:0] out_trip_distance_cm,
  output logic [31:0] out_trip_fuel_ul,
  output logic [31:0] out_trip_idle_waste_ul,
  output logic [23:0] out_air_flow_used,
  output logic        out_fuel_cut,
  output logic        out_last_trip
);

  localparam int unsigned CW = (TRIP_COUNT > 1) ? $clog2(TRIP_COUNT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_IMAP = 3'd2;
  localparam logic [2:0] S_AIR1 = 3'd3;
  localparam logic [2:0] S_ADJ  = 3'd4;
  localparam logic [2:0] S_FUEL = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic          issue_r, issue_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [7:0]  adj_r, disp_r;
  logic [7:0]  thr_min_r, thr_min_nxt;
  logic [31:0] dist_r, dist_nxt, fuel_r, fuel_nxt, waste_r, waste_nxt;

  logic [15:0] ms_r, maf_r;
  logic [7:0]  spd_r, kpa_r;
  logic [13:0] rpm_r;
  logic [9:0]  kelvin_r;
  logic        maf_path_r, sd_ok_r, do_fuel_r, cut_r;
  logic [17:0] imap_r;
  logic [25:0] air1_r;
  logic [23:0] air_r;

  logic        in_xfer, out_xfer;
  logic        thr_ok, fuel_ok;
  logic [7:0]  new_min;
  logic        cut_now;
  logic [10:0] kelvin_w;
  logic [13:0] disp36;

  logic        md_start, md_done;
  md_req_t     md_req;
  logic [MD_AW-1:0] md_quo;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);

  // Front-end decisions on the incoming sample, including the minimum update.
  assign thr_ok  = in_valid_flags[0] && in_engine_running && in_valid_flags[1];
  assign new_min = (thr_ok && in_throttle_position != 8'd0 &&
                    in_throttle_position < thr_min_r) ? in_throttle_position : thr_min_r;
  assign fuel_ok = thr_ok && in_valid_flags[2];
  assign cut_now = fuel_ok && ({1'b0, in_throttle_position} < ({1'b0, new_min} + CUT_MARGIN))
                   && in_fuel_system_status[OPEN_LOOP_BIT];
  assign kelvin_w = {{2{in_intake_temp_c[8]}}, in_intake_temp_c} + KELVIN_OFS;
  assign disp36   = 14'(disp_r) * 14'd36;

  always_comb begin
    md_req = '{a: '0, b: '0, d: DIV_PCT};
    unique case (st_r)
      S_DIST: md_req = '{a: MD_AW'(spd_r), b: ms_r, d: DIV_DIST};
      S_IMAP: md_req = '{a: MD_AW'(rpm_r), b: MD_BW'(kpa_r), d: MD_DW'(kelvin_r)};
      S_AIR1: md_req = '{a: MD_AW'(imap_r), b: MD_BW'(disp36), d: DIV_PCT};
      S_ADJ:  md_req = '{a: maf_path_r ? MD_AW'(maf_r) : MD_AW'(air1_r),
                         b: MD_BW'(adj_r), d: DIV_PCT};
      S_FUEL: md_req = '{a: MD_AW'(air_r), b: ms_r, d: DIV_FUEL};
      default: md_req = '{a: '0, b: '0, d: DIV_PCT};
    endcase
  end

  assign md_start = issue_r && (st_r != S_IDLE) && (st_r != S_OUT);

  tfda_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_comb begin
    st_nxt      = st_r;
    issue_nxt   = 1'b0;
    cnt_nxt     = cnt_r;
    thr_min_nxt = thr_min_r;
    dist_nxt    = dist_r;
    fuel_nxt    = fuel_r;
    waste_nxt   = waste_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          thr_min_nxt = new_min;
          cnt_nxt     = '0;
          issue_nxt   = in_valid_flags[0];
          st_nxt      = in_valid_flags[0] ? S_DIST : S_OUT;
        end
      end
      S_DIST: begin
        if (md_done) begin
          dist_nxt  = dist_r + md_quo[31:0];
          issue_nxt = do_fuel_r;
          st_nxt    = do_fuel_r ? S_IMAP : S_OUT;
        end
      end
      S_IMAP: if (md_done) begin issue_nxt = 1'b1; st_nxt = S_AIR1; end
      S_AIR1: if (md_done) begin issue_nxt = 1'b1; st_nxt = S_ADJ; end
      S_ADJ:  if (md_done) begin issue_nxt = 1'b1; st_nxt = S_FUEL; end
      S_FUEL: begin
        if (md_done) begin
          fuel_nxt = fuel_r + md_quo[31:0];
          if (spd_r == 8'd0) waste_nxt = waste_r + md_quo[31:0];
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          if (cnt_r == CW'(TRIP_COUNT - 1)) st_nxt = S_IDLE;
          else cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      issue_r   <= 1'b0;
      cnt_r     <= '0;
      adj_r     <= ADJ_RESET;
      disp_r    <= DISP_RESET;
      thr_min_r <= THR_MIN_RESET;
      dist_r    <= '0;
      fuel_r    <= '0;
      waste_r   <= '0;
    end else begin
      st_r      <= st_nxt;
      issue_r   <= issue_nxt;
      cnt_r     <= cnt_nxt;
      thr_min_r <= thr_min_nxt;
      dist_r    <= dist_nxt;
      fuel_r    <= fuel_nxt;
      waste_r   <= waste_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ADJ:  adj_r  <= cfg_wdata;
          CFG_DISP: disp_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Sample payload and intermediate results.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ms_r       <= in_elapsed_ms;
      spd_r      <= in_speed_kmh;
      maf_r      <= in_valid_flags[3] ? in_maf_reading : 16'd0;
      rpm_r      <= in_engine_rpm;
      kpa_r      <= in_manifold_kpa;
      kelvin_r   <= kelvin_w[9:0];
      maf_path_r <= in_maf_supported;
      sd_ok_r    <= (in_valid_flags[6:4] == 3'b111);
      do_fuel_r  <= fuel_ok && !cut_now;
      cut_r      <= cut_now;
      air_r      <= '0;
    end
    if (md_done && st_r == S_IMAP) imap_r <= md_quo[17:0];
    if (md_done && st_r == S_AIR1) air1_r <= sd_ok_r ? md_quo[25:0] : 26'd0;
    if (md_done && st_r == S_ADJ)
      air_r <= (md_quo > MD_AW'(AIR_MAX)) ? AIR_MAX : md_quo[23:0];
  end

  assign out_trip_number        = 3'(cnt_r);
  assign out_trip_distance_cm   = dist_r;
  assign out_trip_fuel_ul       = fuel_r;
  assign out_trip_idle_waste_ul = waste_r;
  assign out_air_flow_used      = air_r;
  assign out_fuel_cut           = cut_r;
  assign out_last_trip          = (cnt_r == CW'(TRIP_COUNT - 1));

endmodule

// ----- hdl/tfda_checker.sv -----
// Port-level checker for the trip fuel and distance accumulator, with the
// bind that attaches it to the top level. Depends on no package.
module tfda_checker #(
  parameter int unsigned TRIP_COUNT = 3
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_trip_number,
  input logic [31:0] out_trip_distance_cm,
  input logic        out_last_trip
);

  // Results of a sample come out in trip order, one after another.
  a_trip_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_trip |=>
      out_valid && out_trip_number == $past(out_trip_number) + 3'd1)
    else $error("trip results out of order");

  // No new sample is taken while results are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("sample accepted while results pending");

  a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_trip |-> out_trip_number == 3'(TRIP_COUNT - 1))
    else $error("last trip flag on wrong trip");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trip_distance_cm))
    else $error("stalled result changed");

endmodule

bind trip_fuel_distance_accumulator tfda_checker #(.TRIP_COUNT(TRIP_COUNT)) u_tfda_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_trip_number      (out_trip_number),
  .out_trip_distance_cm (out_trip_distance_cm),
  .out_last_trip        (out_last_trip)
);
